@@ src/opp_pkg.sv @@
package opp_pkg;

	// ODF sample and threshold, unsigned Q8.8
	typedef logic [15:0] odf_t;

	// peak_window register width
	localparam int PW_W = 5;

	// result width (sample position)
	localparam int SAMPLE_W = 33;

	// APB
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// reset values of the configuration registers
	localparam logic [PW_W-1:0] PEAK_WINDOW_RST = 5'd2;
	localparam odf_t ONSET_THRESHOLD_RST = 16'd26;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_PEAK_WINDOW     = 1'b0,
		REG_ONSET_THRESHOLD = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PW_W-1:0] peak_window;
		odf_t            onset_threshold;
	} cfg_t;

endpackage

@@ src/opp_cfg.sv @@
module opp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [opp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [opp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [opp_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output opp_pkg::cfg_t                  cfg
);
	import opp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	assign sel    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_window     <= PEAK_WINDOW_RST;
			cfg_q.onset_threshold <= ONSET_THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (sel)
				REG_PEAK_WINDOW:     cfg_q.peak_window     <= pwdata[PW_W-1:0];
				REG_ONSET_THRESHOLD: cfg_q.onset_threshold <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_PEAK_WINDOW:     prdata = APB_DATA_W'(cfg_q.peak_window);
			REG_ONSET_THRESHOLD: prdata = APB_DATA_W'(cfg_q.onset_threshold);
			default:             prdata = '0;
		endcase
	end

endmodule

@@ src/opp_cell.sv @@
module opp_cell #(
	parameter int IDX   = 0,
	parameter int WIN_W = 5
) (
	input  logic               clk,
	input  logic               shift,
	input  opp_pkg::odf_t      d_in,
	input  opp_pkg::odf_t      center,
	input  logic [WIN_W-1:0]   win,
	output opp_pkg::odf_t      value,
	output logic               ok
);
	import opp_pkg::*;

	localparam logic [7:0] POS = 8'(IDX);

	odf_t       value_q;
	logic [7:0] win8;
	logic       is_newer;
	logic       is_older;
	logic       newer_ok;
	logic       older_ok;

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= d_in;
		end
	end

	assign value = value_q;
	assign win8  = 8'(win);

	// cell IDX holds the frame IDX+1 back; center sits at win-1
	assign is_newer = (POS + 8'd1) < win8;
	assign is_older = ((POS + 8'd1) > win8) && (POS < ((win8 << 1) - 8'd1));

	// 1.5*center >= newer, center >= 1.5*older, done in integers
	assign newer_ok = (18'(center) * 18'd3) >= (18'(value_q) << 1);
	assign older_ok = (18'(center) << 1) >= (18'(value_q) * 18'd3);

	assign ok = (!is_newer || newer_ok) && (!is_older || older_ok);

endmodule

@@ src/onset_peak_picker_core.sv @@
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------
// input    | in        | in_valid/in_stall  | odf_value, restart
// output   | out       | out_valid/out_stall| onset_sample
// config   | in        | APB psel/penable   | paddr, pwdata -> prdata
//
// One frame per cycle while in_stall is low: a frame is judged in the cycle of its transfer
// against the cell row, and the verdict lands in the output register in the next cycle.
// The cell row and the output register set that figure; in_stall is high only
// while the output register holds an untaken result and out_stall is high.
// Reset clears the frame counter, the output valid and the configuration registers.
// The cell contents are not reset; a song only reads frames it wrote itself.
module onset_peak_picker_core #(
	parameter int MAX_WINDOW = 16,
	parameter int HOP_SIZE   = 512,
	parameter int FRAME_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [opp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [opp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [opp_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  opp_pkg::odf_t                  odf_value,
	input  logic                           restart,
	input  logic                           in_valid,
	output logic                           in_stall,
	output logic [opp_pkg::SAMPLE_W-1:0]   onset_sample,
	output logic                           out_valid,
	input  logic                           out_stall
);
	import opp_pkg::*;

	// cells hold the last 2W-1 frames before the current one
	localparam int NCELL  = 2 * MAX_WINDOW - 1;
	localparam int IDX_W  = (NCELL > 1) ? $clog2(NCELL) : 1;
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int HOP_W  = $clog2(HOP_SIZE + 1);
	localparam int PROD_W = FRAME_BITS + HOP_W;
	localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

	cfg_t                  cfg;
	odf_t                  cell_val [NCELL];
	logic [NCELL-1:0]      cell_ok;
	odf_t                  center;
	logic [7:0]            pw8;
	logic [WIN_W-1:0]      win;
	logic [WIN_W:0]        win2;
	logic [IDX_W-1:0]      center_idx;
	logic                  in_take;
	logic [FRAME_BITS-1:0] frame_count_q;
	logic [FRAME_BITS-1:0] frame_k;
	logic [FRAME_BITS-1:0] center_frame;
	logic [PROD_W-1:0]     prod;
	logic                  judge_en;
	logic                  thr_ok;
	logic                  emit;
	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   onset_sample_q;

	opp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// clamp the window to 1..MAX_WINDOW
	always_comb begin
		pw8 = 8'(cfg.peak_window);
		if (pw8 == 8'd0) begin
			win = WIN_W'(1);
		end else if (pw8 > 8'(MAX_WINDOW)) begin
			win = WIN_W'(MAX_WINDOW);
		end else begin
			win = WIN_W'(pw8);
		end
	end

	assign win2       = (WIN_W + 1)'(win) << 1;
	assign center_idx = IDX_W'(win - WIN_W'(1));
	assign center     = cell_val[center_idx];

	assign in_stall = out_valid_q & out_stall;
	assign in_take  = in_valid & ~in_stall;

	// shift the row on every transfer; cell 0 takes the new frame
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		odf_t d_in;
		if (i == 0) begin : g_head
			assign d_in = odf_value;
		end else begin : g_link
			assign d_in = cell_val[i-1];
		end
		opp_cell #(
			.IDX   (i),
			.WIN_W (WIN_W)
		) u_cell (
			.clk    (clk),
			.shift  (in_take),
			.d_in   (d_in),
			.center (center),
			.win    (win),
			.value  (cell_val[i]),
			.ok     (cell_ok[i])
		);
	end

	// index of the arriving frame; restart makes it frame 0
	assign frame_k = restart ? '0 : frame_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
		end else if (in_take) begin
			// saturate: hold at the top value
			if (frame_k != FRAME_MAX) begin
				frame_count_q <= frame_k + FRAME_BITS'(1);
			end else begin
				frame_count_q <= frame_k;
			end
		end
	end

	// judge frame k-W once k >= 2W, never at the saturated index
	assign judge_en = !restart && (frame_k != FRAME_MAX) &&
		(32'(frame_k) >= 32'(win2));
	// threshold only counts when the window has neighbors
	assign thr_ok   = (win == WIN_W'(1)) || (center >= cfg.onset_threshold);
	assign emit     = restart || (judge_en && thr_ok && (&cell_ok));

	assign center_frame = frame_k - FRAME_BITS'(win);
	assign prod         = PROD_W'(center_frame) * PROD_W'(HOP_SIZE);

	// output register: load on transfer, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			onset_sample_q <= restart ? '0 : SAMPLE_W'(prod);
		end
	end

	assign out_valid    = out_valid_q;
	assign onset_sample = onset_sample_q;

	a_restart_onset: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && restart |=> out_valid_q && (onset_sample_q == '0))
		else $error("restart frame did not yield the onset at sample 0");

	a_restart_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && restart |=> frame_count_q == FRAME_BITS'(1))
		else $error("frame counter not advanced to 1 after restart");

	a_count_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !restart |=> frame_count_q >= $past(frame_count_q))
		else $error("frame counter went back without restart");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_take))
		else $error("result appeared without an input transfer");

endmodule
